@@ rtl/tlbfl_pkg.sv @@
// Package for the TLB lookup block: sizes, register indexes, controller commands.
// No dependencies.
`default_nettype none
package tlbfl_pkg;
	localparam int TlbEntriesDef = 32;
	localparam int PidW = 16;
	localparam int PageW = 20;
	localparam int OffW = 16;
	localparam int FrameW = 20;
	localparam int PaW = 36;
	localparam int SlotW = 5;
	localparam int LimW = 6;
	localparam int PsW = 17;
	localparam int StampW = 32;
	localparam int AddrW = 4;

	localparam logic [AddrW-1:0] RegMode = 4'd0;
	localparam logic [AddrW-1:0] RegLimit = 4'd4;
	localparam logic [AddrW-1:0] RegPsize = 4'd8;

	localparam logic KindLookup = 1'b0;
	localparam logic KindFill = 1'b1;

	typedef struct packed {
		logic load;     // capture input word, start search
		logic commit;   // write/stamp entry, form result
	} dp_cmd_t;

	typedef struct packed {
		logic done;     // scan finished
	} dp_sts_t;
endpackage
`default_nettype wire

@@ rtl/tlbfl_if.sv @@
// Valid/ready channel interfaces for the TLB block.
// Depends on tlbfl_pkg.
`default_nettype none
interface tlbfl_in_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [tlbfl_pkg::PidW-1:0]   process_id;
	logic [tlbfl_pkg::PageW-1:0]  page_number;
	logic [tlbfl_pkg::OffW-1:0]   offset;
	logic [tlbfl_pkg::FrameW-1:0] fill_frame;
	modport source (output valid, kind, process_id, page_number, offset, fill_frame,
		input ready);
	modport sink (input valid, kind, process_id, page_number, offset, fill_frame,
		output ready);
endinterface

interface tlbfl_out_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [tlbfl_pkg::FrameW-1:0] frame_number;
	logic [tlbfl_pkg::PaW-1:0]    physical_address;
	logic [tlbfl_pkg::SlotW-1:0]  slot_index;
	modport source (output valid, hit, frame_number, physical_address, slot_index,
		input ready);
	modport sink (input valid, hit, frame_number, physical_address, slot_index,
		output ready);
endinterface
`default_nettype wire

@@ rtl/tlbfl_ctrl.sv @@
// Controller: one-hot FSM sequencing load, scan wait, commit and result hold.
// Depends on tlbfl_pkg.
`default_nettype none
module tlbfl_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tlbfl_pkg::dp_cmd_t      cmd,
	input  wire tlbfl_pkg::dp_sts_t sts
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		cmd.load = in_valid && (state_q == ST_IDLE);
		cmd.commit = (state_q == ST_SCAN) && sts.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SCAN;
				ST_SCAN: if (sts.done) state_q <= ST_OUT;
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/tlbfl_dp.sv @@
// Datapath: entry arrays, tag match, victim scan, stamps and address multiply.
// Depends on tlbfl_pkg.
`default_nettype none
module tlbfl_dp #(
	parameter int TLB_ENTRIES = tlbfl_pkg::TlbEntriesDef
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire tlbfl_pkg::dp_cmd_t              cmd,
	output tlbfl_pkg::dp_sts_t                   sts,
	input  wire logic                            replace_mode,
	input  wire logic [tlbfl_pkg::LimW-1:0]      entry_limit,
	input  wire logic [tlbfl_pkg::PsW-1:0]       page_size,
	input  wire logic                            kind,
	input  wire logic [tlbfl_pkg::PidW-1:0]      process_id,
	input  wire logic [tlbfl_pkg::PageW-1:0]     page_number,
	input  wire logic [tlbfl_pkg::OffW-1:0]      offset,
	input  wire logic [tlbfl_pkg::FrameW-1:0]    fill_frame,
	output logic                                 hit,
	output logic [tlbfl_pkg::FrameW-1:0]         frame_number,
	output logic [tlbfl_pkg::PaW-1:0]            physical_address,
	output logic [tlbfl_pkg::SlotW-1:0]          slot_index
);
	localparam int IdxW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int CntW = $clog2(TLB_ENTRIES + 1);
	localparam int SW = tlbfl_pkg::StampW;

	logic [tlbfl_pkg::PidW-1:0]   pid_q [TLB_ENTRIES];
	logic [tlbfl_pkg::PageW-1:0]  page_q [TLB_ENTRIES];
	logic [tlbfl_pkg::FrameW-1:0] frame_q [TLB_ENTRIES];
	logic [SW-1:0]                birth_q [TLB_ENTRIES];
	logic [SW-1:0]                use_q [TLB_ENTRIES];
	logic [CntW-1:0]              filled_q;
	logic [SW-1:0]                time_q;

	logic                         kind_q;
	logic [tlbfl_pkg::PidW-1:0]   pid_in_q;
	logic [tlbfl_pkg::PageW-1:0]  page_in_q;
	logic [tlbfl_pkg::OffW-1:0]   off_q;
	logic [tlbfl_pkg::FrameW-1:0] fframe_q;

	// scan: one entry per cycle, tracks first match and oldest stamp
	logic [CntW-1:0]              scan_q;
	logic                         found_q;
	logic [IdxW-1:0]              match_q;
	logic [IdxW-1:0]              best_q;
	logic [SW-1:0]                best_stamp_q;
	logic                         scan_end;
	logic [IdxW-1:0]              scan_idx;
	logic [SW-1:0]                cur_stamp;

	assign scan_idx = scan_q[IdxW-1:0];
	assign scan_end = (scan_q >= filled_q) || (scan_q == CntW'(TLB_ENTRIES));
	assign cur_stamp = replace_mode ? use_q[scan_idx] : birth_q[scan_idx];

	// product formed combinationally from registers loaded on commit
	logic [tlbfl_pkg::FrameW-1:0] frm_s1;
	logic [tlbfl_pkg::OffW-1:0]   off_s1;
	logic                         hit_s1;
	logic [tlbfl_pkg::SlotW-1:0]  slot_s1;

	assign sts.done = scan_end && !cmd.load;

	logic [CntW-1:0] lim_eff;
	always_comb begin
		if (entry_limit == '0) lim_eff = CntW'(1);
		else if ({1'b0, entry_limit} > 7'(TLB_ENTRIES)) lim_eff = CntW'(TLB_ENTRIES);
		else lim_eff = CntW'(entry_limit);
	end

	logic [IdxW-1:0] wr_idx;
	logic            take_free;
	assign take_free = filled_q < lim_eff;
	assign wr_idx = take_free ? filled_q[IdxW-1:0] : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			time_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end else if (!scan_end && !found_q) begin
				if (kind_q == tlbfl_pkg::KindLookup &&
					pid_q[scan_idx] == pid_in_q && page_q[scan_idx] == page_in_q) begin
					found_q <= 1'b1;
					scan_q <= filled_q;
				end else begin
					scan_q <= scan_q + CntW'(1);
				end
			end
			if (cmd.commit) begin
				if (kind_q == tlbfl_pkg::KindFill) begin
					if (take_free) filled_q <= filled_q + CntW'(1);
					time_q <= time_q + SW'(1);
				end else if (found_q && replace_mode) begin
					time_q <= time_q + SW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			pid_in_q <= process_id;
			page_in_q <= page_number;
			off_q <= offset;
			fframe_q <= fill_frame;
			best_q <= '0;
			best_stamp_q <= '1;
		end else if (!scan_end && !found_q) begin
			if (kind_q == tlbfl_pkg::KindLookup &&
				pid_q[scan_idx] == pid_in_q && page_q[scan_idx] == page_in_q)
				match_q <= scan_idx;
			if (scan_q == '0 || cur_stamp < best_stamp_q) begin
				best_q <= scan_idx;
				best_stamp_q <= cur_stamp;
			end
		end
		if (cmd.commit) begin
			if (kind_q == tlbfl_pkg::KindFill) begin
				pid_q[wr_idx] <= pid_in_q;
				page_q[wr_idx] <= page_in_q;
				frame_q[wr_idx] <= fframe_q;
				birth_q[wr_idx] <= time_q;
				use_q[wr_idx] <= time_q;
				hit_s1 <= 1'b1;
				frm_s1 <= fframe_q;
				off_s1 <= off_q;
				slot_s1 <= tlbfl_pkg::SlotW'(wr_idx);
			end else if (found_q) begin
				if (replace_mode) use_q[match_q] <= time_q;
				hit_s1 <= 1'b1;
				frm_s1 <= frame_q[match_q];
				off_s1 <= off_q;
				slot_s1 <= tlbfl_pkg::SlotW'(match_q);
			end else begin
				hit_s1 <= 1'b0;
				frm_s1 <= '0;
				off_s1 <= '0;
				slot_s1 <= '0;
			end
		end
	end

	// output stage: multiply is one 17x20 product plus offset
	logic [tlbfl_pkg::PaW-1:0] prod;
	assign prod = tlbfl_pkg::PaW'(page_size) * tlbfl_pkg::PaW'(frm_s1)
		+ tlbfl_pkg::PaW'(off_s1);
	always_comb begin
		hit = hit_s1;
		frame_number = frm_s1;
		physical_address = hit_s1 ? prod : '0;
		slot_index = slot_s1;
	end
endmodule
`default_nettype wire

@@ rtl/tlb_lookup_with_fifo_lru_replacement.sv @@
// Fully associative TLB tagged by process id and page, FIFO or LRU replacement.
// An item goes through accept, a sequential tag and victim scan over the entry
// arrays (the filled entries, or up to and including the matching one on a
// lookup hit; at most TLB_ENTRIES entries), commit, and result presentation;
// the result then holds until taken. One item is in flight at a time.
// Depends on tlbfl_pkg, tlbfl_if, tlbfl_ctrl, tlbfl_dp.
`default_nettype none
module tlb_lookup_with_fifo_lru_replacement #(
	parameter int TLB_ENTRIES = tlbfl_pkg::TlbEntriesDef
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tlbfl_in_if.sink                           in_ch,
	tlbfl_out_if.source                        out_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tlbfl_pkg::AddrW-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	logic                         mode_q;
	logic [tlbfl_pkg::LimW-1:0]   limit_q;
	logic [tlbfl_pkg::PsW-1:0]    psize_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			limit_q <= 6'd32;
			psize_q <= 17'd4096;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr)
				tlbfl_pkg::RegMode: mode_q <= pwdata[0];
				tlbfl_pkg::RegLimit: limit_q <= pwdata[tlbfl_pkg::LimW-1:0];
				tlbfl_pkg::RegPsize: psize_q <= pwdata[tlbfl_pkg::PsW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			tlbfl_pkg::RegMode: prdata = {31'd0, mode_q};
			tlbfl_pkg::RegLimit: prdata = {26'd0, limit_q};
			tlbfl_pkg::RegPsize: prdata = {15'd0, psize_q};
			default: prdata = '0;
		endcase
	end

	tlbfl_pkg::dp_cmd_t cmd;
	tlbfl_pkg::dp_sts_t sts;

	tlbfl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	tlbfl_dp #(.TLB_ENTRIES(TLB_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.replace_mode(mode_q), .entry_limit(limit_q), .page_size(psize_q),
		.kind(in_ch.kind), .process_id(in_ch.process_id),
		.page_number(in_ch.page_number), .offset(in_ch.offset),
		.fill_frame(in_ch.fill_frame),
		.hit(out_ch.hit), .frame_number(out_ch.frame_number),
		.physical_address(out_ch.physical_address), .slot_index(out_ch.slot_index)
	);
endmodule
`default_nettype wire

@@ tb/sv/tb_tlb_lookup_with_fifo_lru_replacement.sv @@
// Testbench for the TLB lookup block: directed table, setting edges, then random lookups and fills,
// all checked against a behavioral TLB model kept here. Depends on tlbfl_pkg, tlbfl_if.
`default_nettype none
module tb_tlb_lookup_with_fifo_lru_replacement;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Entries = 32;

	typedef struct packed {
		logic                        kind;
		logic [tlbfl_pkg::PidW-1:0]   pid;
		logic [tlbfl_pkg::PageW-1:0]  page;
		logic [tlbfl_pkg::OffW-1:0]   off;
		logic [tlbfl_pkg::FrameW-1:0] frame;
	} tlb_req_t;

	typedef struct packed {
		logic                        hit;
		logic [tlbfl_pkg::FrameW-1:0] frame;
		logic [tlbfl_pkg::PaW-1:0]    pa;
		logic [tlbfl_pkg::SlotW-1:0]  slot;
	} tlb_rsp_t;

	typedef struct {
		tlb_req_t req;
		logic     known;  // expected response typed in by hand
		tlb_rsp_t rsp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [tlbfl_pkg::AddrW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tlbfl_in_if in_ch ();
	tlbfl_out_if out_ch ();

	tlb_lookup_with_fifo_lru_replacement u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model state
	logic                        m_mode;
	logic [tlbfl_pkg::LimW-1:0]   m_limit;
	logic [tlbfl_pkg::PsW-1:0]    m_psize;
	logic [tlbfl_pkg::PidW-1:0]   m_pid [Entries];
	logic [tlbfl_pkg::PageW-1:0]  m_page [Entries];
	logic [tlbfl_pkg::FrameW-1:0] m_frame [Entries];
	logic [31:0]                 m_birth [Entries];
	logic [31:0]                 m_used [Entries];
	int                          m_filled;
	logic [31:0]                 m_clock;

	tlb_rsp_t pending_rsp[$];
	int errors = 0;
	logic hold_off = 1'b0;
	logic sink_on = 1'b0;

	function automatic logic [tlbfl_pkg::PaW-1:0] phys(logic [tlbfl_pkg::FrameW-1:0] f,
		logic [tlbfl_pkg::OffW-1:0] o);
		logic [63:0] p;
		p = 64'(m_psize) * 64'(f) + 64'(o);
		return p[tlbfl_pkg::PaW-1:0];
	endfunction

	function automatic tlb_rsp_t translate(tlb_req_t r);
		tlb_rsp_t o;
		int lim, v;
		o = '0;
		if (r.kind == tlbfl_pkg::KindLookup) begin
			for (int i = 0; i < m_filled; i++) begin
				if (m_pid[i] == r.pid && m_page[i] == r.page) begin
					if (m_mode) begin
						m_used[i] = m_clock;
						m_clock++;
					end
					o.hit = 1'b1;
					o.frame = m_frame[i];
					o.pa = phys(m_frame[i], r.off);
					o.slot = tlbfl_pkg::SlotW'(i);
					return o;
				end
			end
			return o;
		end
		lim = (m_limit < 1) ? 1 : (m_limit > Entries ? Entries : int'(m_limit));
		if (m_filled < lim) begin
			v = m_filled;
			m_filled++;
		end else begin
			v = 0;
			for (int i = 1; i < m_filled; i++)
				if (m_mode ? (m_used[i] < m_used[v]) : (m_birth[i] < m_birth[v]))
					v = i;
		end
		m_pid[v] = r.pid;
		m_page[v] = r.page;
		m_frame[v] = r.frame;
		m_birth[v] = m_clock;
		m_used[v] = m_clock;
		m_clock++;
		o.hit = 1'b1;
		o.frame = r.frame;
		o.pa = phys(r.frame, r.off);
		o.slot = tlbfl_pkg::SlotW'(v);
		return o;
	endfunction

	task automatic reg_write(logic [tlbfl_pkg::AddrW-1:0] a, logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (a)
			tlbfl_pkg::RegMode: m_mode = d[0];
			tlbfl_pkg::RegLimit: m_limit = d[tlbfl_pkg::LimW-1:0];
			tlbfl_pkg::RegPsize: m_psize = d[tlbfl_pkg::PsW-1:0];
			default: ;
		endcase
	endtask

	// valid stays high after an accept; it drops at the next gap or in drain
	task automatic send_word(tlb_req_t r);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		{in_ch.kind, in_ch.process_id, in_ch.page_number, in_ch.offset, in_ch.fill_frame} <= r;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_rsp.push_back(translate(r));
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (Entries + 8) @(posedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		wait (sink_on);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 50) : $urandom_range(1, 3);
				out_ch.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			tlb_rsp_t got, want;
			got = {out_ch.hit, out_ch.frame_number, out_ch.physical_address, out_ch.slot_index};
			if (pending_rsp.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: %h", got);
			end else begin
				want = pending_rsp.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: hit %b/%b frame %h/%h pa %h/%h slot %0d/%0d",
							want.hit, got.hit, want.frame, got.frame,
							want.pa, got.pa, want.slot, got.slot);
				end
			end
		end
	end

	function automatic tlb_req_t mk(logic k, logic [tlbfl_pkg::PidW-1:0] p,
		logic [tlbfl_pkg::PageW-1:0] g, logic [tlbfl_pkg::OffW-1:0] o,
		logic [tlbfl_pkg::FrameW-1:0] f);
		return '{k, p, g, o, f};
	endfunction

	// random item: mostly tags from a small pool so lookups hit and fills replace
	function automatic tlb_req_t rand_req(int pool);
		tlb_req_t r;
		r.kind = $urandom_range(0, 2) == 0;
		if ($urandom_range(0, 7) == 0) begin
			r.pid = tlbfl_pkg::PidW'($urandom);
			r.page = tlbfl_pkg::PageW'($urandom);
		end else begin
			r.pid = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) ^
				tlbfl_pkg::PidW'($urandom_range(0, 3));
			r.page = ($urandom_range(0, 1) ? 20'hFFFFF : 20'h0) ^
				tlbfl_pkg::PageW'($urandom_range(0, pool));
		end
		r.off = tlbfl_pkg::OffW'($urandom);
		r.frame = tlbfl_pkg::FrameW'($urandom);
		return r;
	endfunction

	initial begin
		dir_row_t dir[$];
		m_mode = 1'b0; m_limit = 6'd32; m_psize = 17'd4096;
		m_filled = 0; m_clock = '0;
		in_ch.valid = 1'b0; in_ch.kind = tlbfl_pkg::KindLookup; in_ch.process_id = '0;
		in_ch.page_number = '0; in_ch.offset = '0; in_ch.fill_frame = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		sink_on = 1'b1;

		// directed: miss on empty, extremes, duplicate tags, zero page size, limit edges
		dir.push_back('{mk(tlbfl_pkg::KindLookup, 16'h0, 20'h0, 16'h0, 20'h0), 1'b1, '0});
		dir.push_back('{mk(tlbfl_pkg::KindFill, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 20'hFFFFF), 1'b1,
			'{1'b1, 20'hFFFFF, tlbfl_pkg::PaW'(64'd4096 * 64'hFFFFF + 64'hFFFF), 5'd0}});
		dir.push_back('{mk(tlbfl_pkg::KindLookup, 16'hFFFF, 20'hFFFFF, 16'h0, 20'h0), 1'b0, '0});
		dir.push_back('{mk(tlbfl_pkg::KindFill, 16'h0, 20'h0, 16'h0, 20'h0), 1'b0, '0});
		dir.push_back('{mk(tlbfl_pkg::KindFill, 16'h0, 20'h0, 16'h1, 20'h5), 1'b0, '0});
		dir.push_back('{mk(tlbfl_pkg::KindLookup, 16'h0, 20'h0, 16'h7, 20'h0), 1'b0, '0});
		dir.push_back('{mk(tlbfl_pkg::KindLookup, 16'hFFFF, 20'h0, 16'h7, 20'h0), 1'b1, '0});
		foreach (dir[i]) begin
			send_word(dir[i].req);
			if (dir[i].known && pending_rsp[$] !== dir[i].rsp) begin
				errors++;
				if (errors <= 10) $display("row %0d: model disagrees with table", i);
			end
		end
		drain();

		reg_write(tlbfl_pkg::RegPsize, 32'd0);
		reg_write(tlbfl_pkg::RegMode, 32'd1);
		reg_write(tlbfl_pkg::RegLimit, 32'd0);  // acts as one
		for (int i = 0; i < 4; i++)
			send_word(mk(i[0], 16'h1, 20'h2, 16'hABCD, tlbfl_pkg::FrameW'(i + 3)));
		drain();
		reg_write(tlbfl_pkg::RegLimit, 32'd33);  // clamps to full size
		reg_write(tlbfl_pkg::RegPsize, 32'h1FFFF);
		for (int i = 0; i < 8; i++)
			send_word(mk(tlbfl_pkg::KindFill, 16'h2, 20'(i), 16'hFFFF, 20'hFFFFF));
		drain();
		reg_write(tlbfl_pkg::RegLimit, 32'd2);  // below fill count
		send_word(mk(tlbfl_pkg::KindFill, 16'h3, 20'h3, 16'h0, 20'h1));
		send_word(mk(tlbfl_pkg::KindLookup, 16'h2, 20'h5, 16'h1, 20'h0));
		drain();

		// random phases through settings; each ends with the sender idle until all results are in
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					reg_write(tlbfl_pkg::RegMode, 0); reg_write(tlbfl_pkg::RegLimit, 32);
					reg_write(tlbfl_pkg::RegPsize, 4096);
				end
				1: begin
					reg_write(tlbfl_pkg::RegMode, 1); reg_write(tlbfl_pkg::RegLimit, 1);
					reg_write(tlbfl_pkg::RegPsize, 1);
				end
				2: begin
					reg_write(tlbfl_pkg::RegMode, 1); reg_write(tlbfl_pkg::RegLimit, 32);
					reg_write(tlbfl_pkg::RegPsize, 65536);
				end
				3: begin
					reg_write(tlbfl_pkg::RegMode, 0); reg_write(tlbfl_pkg::RegLimit, 4);
					reg_write(tlbfl_pkg::RegPsize, 131071);
				end
				default: begin
					reg_write(tlbfl_pkg::RegMode, $urandom_range(0, 1));
					reg_write(tlbfl_pkg::RegLimit, $urandom_range(0, 33));
					reg_write(tlbfl_pkg::RegPsize, $urandom);
				end
			endcase
			if (ph == 2) hold_off <= 1'b1;
			for (int k = 0; k < 190; k++) send_word(rand_req(ph < 4 ? 12 : 40));
			drain();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#8ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
rtl/tlbfl_pkg.sv
rtl/tlbfl_if.sv
rtl/tlbfl_ctrl.sv
rtl/tlbfl_dp.sv
rtl/tlb_lookup_with_fifo_lru_replacement.sv
tb/sv/tb_tlb_lookup_with_fifo_lru_replacement.sv
